### design/ohc_pkg.sv
// Shared types, widths and register codes for the 4x oversampled hard clipper.
`timescale 1ns / 1ps
`default_nettype none

package ohc_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int CFG_IDX_W    = 1;
    localparam int CHANNELS_DEF = 2;
    localparam int SLOTS        = 2;   // the channel field is one bit wide
    localparam int POINTS       = 4;
    localparam int HIST_LEN     = 3;

    // Interpolation sums span up to four times a sample: two extra bits plus sign margin.
    localparam int PT_W  = SAMPLE_W + 3;
    // Filter sum spans up to sixteen times a sample.
    localparam int ACC_W = SAMPLE_W + 5;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef sample_t points_t [POINTS];     // quarter, half, three-quarter, new point
    typedef sample_t hist_t [HIST_LEN];     // new, three-quarter, half of the prior step

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOW_THR  = 1'b0,
        REG_HIGH_THR = 1'b1
    } cfg_reg_t;

    localparam sample_t LOW_THR_RST  = sample_t'(-32768);
    localparam sample_t HIGH_THR_RST = sample_t'(32767);
    localparam sample_t SAMPLE_MAX   = sample_t'(32767);
    localparam sample_t SAMPLE_MIN   = sample_t'(-32768);

endpackage

`default_nettype wire

### design/ohc_in_if.sv
// Input sample channel: valid/ready handshake carrying channel and sample.
`timescale 1ns / 1ps
`default_nettype none

interface ohc_in_if;

    logic             valid;
    logic             ready;
    logic             channel;
    ohc_pkg::sample_t sample_in;

    modport source (output valid, output channel, output sample_in, input ready);
    modport sink   (input valid, input channel, input sample_in, output ready);

endinterface

`default_nettype wire

### design/ohc_out_if.sv
// Result channel: valid/ready handshake carrying channel and filtered sample.
`timescale 1ns / 1ps
`default_nettype none

interface ohc_out_if;

    logic             valid;
    logic             ready;
    logic             channel_out;
    ohc_pkg::sample_t sample_out;

    modport source (output valid, output channel_out, output sample_out, input ready);
    modport sink   (input valid, input channel_out, input sample_out, output ready);

endinterface

`default_nettype wire

### design/ohc_interp_clip.sv
// Four-point linear interpolation toward the new sample, each point hard-clipped.
`timescale 1ns / 1ps
`default_nettype none

module ohc_interp_clip (
    input  ohc_pkg::sample_t prev,
    input  ohc_pkg::sample_t sample,
    input  ohc_pkg::sample_t low_thr,
    input  ohc_pkg::sample_t high_thr,
    output ohc_pkg::points_t points
);
    import ohc_pkg::*;

    logic signed [PT_W-1:0] p_ext;
    logic signed [PT_W-1:0] x_ext;
    logic signed [PT_W-1:0] sums [POINTS];
    logic signed [PT_W-1:0] rnd  [POINTS];
    sample_t                lowered [POINTS];

    assign p_ext = PT_W'(prev);
    assign x_ext = PT_W'(sample);

    // Weights (3,1), (2,2), (1,3), (0,4) on previous and new sample.
    assign sums[0] = (p_ext <<< 1) + p_ext + x_ext;
    assign sums[1] = (p_ext <<< 1) + (x_ext <<< 1);
    assign sums[2] = p_ext + (x_ext <<< 1) + x_ext;
    assign sums[3] = x_ext <<< 2;

    // Round to nearest with halves upward, then clamp low first and high last, so an
    // inverted pair of thresholds yields the high threshold.
    always_comb
    begin
        for (int i = 0; i < POINTS; i++)
        begin
            rnd[i]     = sums[i] + PT_W'(2);
            lowered[i] = ($signed(rnd[i][SAMPLE_W+1:2]) < low_thr) ? low_thr
                                                                   : $signed(rnd[i][SAMPLE_W+1:2]);
            points[i]  = (lowered[i] > high_thr) ? high_thr : lowered[i];
        end
    end

endmodule

`default_nettype wire

### design/ohc_decim.sv
// Seven-tap triangular decimator (1,2,3,4,3,2,1)/16 with rounding and saturation.
`timescale 1ns / 1ps
`default_nettype none

module ohc_decim (
    input  ohc_pkg::points_t points,
    input  ohc_pkg::hist_t   hist,
    output ohc_pkg::sample_t result
);
    import ohc_pkg::*;

    localparam int SH_W = ACC_W - 4;

    logic signed [ACC_W-1:0] q [POINTS];
    logic signed [ACC_W-1:0] h [HIST_LEN];
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] acc_rnd;
    logic signed [SH_W-1:0]  scaled;

    always_comb
    begin
        for (int i = 0; i < POINTS; i++)
        begin
            q[i] = ACC_W'(points[i]);
        end
        for (int i = 0; i < HIST_LEN; i++)
        begin
            h[i] = ACC_W'(hist[i]);
        end
    end

    // Taps oldest to newest: half, three-quarter, new of the prior step, then
    // quarter, half, three-quarter, new of this step.
    assign acc = h[2] + (h[1] <<< 1) + (h[0] <<< 1) + h[0]
               + (q[0] <<< 2) + (q[1] <<< 1) + q[1] + (q[2] <<< 1) + q[3];

    assign acc_rnd = acc + ACC_W'(8);
    assign scaled  = acc_rnd[ACC_W-1:4];

    always_comb
    begin
        if (scaled > SH_W'(SAMPLE_MAX))
        begin
            result = SAMPLE_MAX;
        end
        else if (scaled < SH_W'(SAMPLE_MIN))
        begin
            result = SAMPLE_MIN;
        end
        else
        begin
            result = scaled[SAMPLE_W-1:0];
        end
    end

endmodule

`default_nettype wire

### design/oversampled_hard_clipper_4x.sv
// Top level of the 4x oversampled hard clipper with triangular decimation.
//
// Usage: samples arrive on sample_ch, one beat per sample, tagged with a one-bit
// channel. Each beat produces exactly one beat on result_ch carrying the same
// channel bit and the clipped, filtered sample, in arrival order.
// Thresholds are set through cfg_we / cfg_index / cfg_data while no beat is in
// flight; index 0 is the low clip level and index 1 the high clip level.
// Data path: an accepted beat is registered, processed in one pass of
// combinational logic and loaded into the result register when the result
// stage is empty or being emptied, and is then offered on result_ch.
// Throughput: one beat per cycle, sustained while result_ch is ready, including
// back-to-back beats of the same channel; the per-channel history is written
// on the same edge that loads the result register, so the next beat sees it.
// Stalls: when result_ch is not ready, the result register holds its beat and
// the input register still takes one more beat; sample_ch drops ready only when
// both are full. No beat is lost or repeated.
// Reset: clears both stage valid flags, the per-channel previous samples and
// clipped history to zero, and the thresholds to full scale.
`timescale 1ns / 1ps
`default_nettype none

module oversampled_hard_clipper_4x #(
    parameter int CHANNELS = ohc_pkg::CHANNELS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [ohc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ohc_pkg::SAMPLE_W-1:0]  cfg_data,
    ohc_in_if.sink                             sample_ch,
    ohc_out_if.source                          result_ch
);
    import ohc_pkg::*;

    // Threshold registers.
    sample_t low_thr_reg;
    sample_t high_thr_reg;

    // Input stage.
    logic    in_vld_reg;
    logic    in_ch_reg;
    sample_t in_smp_reg;

    // Result stage.
    logic    out_vld_reg;
    logic    out_ch_reg;
    sample_t out_smp_reg;

    // Per-channel state.
    sample_t prev_reg [SLOTS];
    hist_t   hist_reg [SLOTS];

    logic    advance;
    logic    slot;
    points_t points;
    sample_t filtered;

    // With a single channel every beat shares slot zero.
    assign slot    = (CHANNELS > 1) ? in_ch_reg : 1'b0;
    assign advance = in_vld_reg && (!out_vld_reg || result_ch.ready);

    assign sample_ch.ready = !in_vld_reg || advance;

    assign result_ch.valid       = out_vld_reg;
    assign result_ch.channel_out = out_ch_reg;
    assign result_ch.sample_out  = out_smp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_thr_reg  <= LOW_THR_RST;
            high_thr_reg <= HIGH_THR_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_LOW_THR:  low_thr_reg  <= sample_t'(cfg_data);
                REG_HIGH_THR: high_thr_reg <= sample_t'(cfg_data);
                default:      ;
            endcase
        end
    end

    // Stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (sample_ch.ready)
            begin
                in_vld_reg <= sample_ch.valid;
            end
            if (advance)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (result_ch.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (sample_ch.valid && sample_ch.ready)
        begin
            in_ch_reg  <= sample_ch.channel;
            in_smp_reg <= sample_ch.sample_in;
        end
        if (advance)
        begin
            out_ch_reg  <= in_ch_reg;
            out_smp_reg <= filtered;
        end
    end

    // The history keeps this step's new, three-quarter and half points.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SLOTS; s++)
            begin
                prev_reg[s] <= '0;
                for (int k = 0; k < HIST_LEN; k++)
                begin
                    hist_reg[s][k] <= '0;
                end
            end
        end
        else if (advance)
        begin
            prev_reg[slot]    <= in_smp_reg;
            hist_reg[slot][0] <= points[3];
            hist_reg[slot][1] <= points[2];
            hist_reg[slot][2] <= points[1];
        end
    end

    ohc_interp_clip u_interp_clip (
        .prev     (prev_reg[slot]),
        .sample   (in_smp_reg),
        .low_thr  (low_thr_reg),
        .high_thr (high_thr_reg),
        .points   (points)
    );

    ohc_decim u_decim (
        .points (points),
        .hist   (hist_reg[slot]),
        .result (filtered)
    );

endmodule

`default_nettype wire

### sim/testbench.sv
// Self-checking testbench for the 4x oversampled hard clipper with triangular decimation.
`timescale 1ns / 1ps

module testbench;

    import ohc_pkg::*;

    // One sample beat as it is offered on the input channel.
    typedef struct packed {
        logic    channel;
        sample_t sample;
    } in_beat_t;

    // One filtered beat as it is expected on the result channel.
    typedef struct packed {
        logic    channel;
        sample_t sample;
    } out_beat_t;

    localparam int CYCLE_LIMIT       = 200000;
    localparam int BEATS_PER_SETTING = 44;
    localparam int SETTINGS_PER_PASS = 8;
    localparam int DRAIN_CYCLES      = 8;

    logic     clk;
    logic     rst_n;
    logic     cfg_we;
    cfg_reg_t cfg_index;
    sample_t  cfg_data;

    ohc_in_if  sample_bus ();
    ohc_out_if result_bus ();

    oversampled_hard_clipper_4x u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample_ch (sample_bus),
        .result_ch (result_bus)
    );

    // Beats waiting to be offered, and filtered beats waiting to come out.
    in_beat_t  pending_beats[$];
    out_beat_t expected_results[$];

    // Our own copy of the block's state: clip levels, the last sample of each
    // channel and the three clipped points each channel keeps for the filter.
    sample_t low_thr;
    sample_t high_thr;
    sample_t prev_sample [SLOTS];
    sample_t clip_hist   [SLOTS][HIST_LEN];

    // Percentages of cycles in which the sender holds back or the receiver stalls.
    int send_idle_pct;
    int recv_idle_pct;

    int mismatches;
    int cycle_count;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard clip against the current levels. When the levels are inverted the
    // second comparison wins, so every point lands on the high level.
    function automatic int clip_level(int v);
        int y;
        y = (v < int'(low_thr)) ? int'(low_thr) : v;
        return (y > int'(high_thr)) ? int'(high_thr) : y;
    endfunction

    // Interpolates four points from the channel's previous sample toward the new
    // one, clips them, runs the 1,2,3,4,3,2,1 / 16 filter over them and the three
    // points kept from the last beat, and advances the channel's history.
    function automatic out_beat_t clip_and_decimate(logic ch, sample_t x);
        int        prev;
        int        xi;
        int        q1;
        int        q2;
        int        q3;
        int        q4;
        int        acc;
        int        y;
        out_beat_t r;
        prev = prev_sample[ch];
        xi   = x;
        // Each point rounds to nearest with halves going up (floor shift of sum + 2).
        q1 = clip_level((3 * prev + xi + 2) >>> 2);
        q2 = clip_level((2 * prev + 2 * xi + 2) >>> 2);
        q3 = clip_level((prev + 3 * xi + 2) >>> 2);
        q4 = clip_level(xi);
        acc = q4 + 2 * q3 + 3 * q2 + 4 * q1
            + 3 * int'(clip_hist[ch][0]) + 2 * int'(clip_hist[ch][1]) + int'(clip_hist[ch][2]);
        y = (acc + 8) >>> 4;
        if (y > int'(SAMPLE_MAX))
        begin
            y = SAMPLE_MAX;
        end
        if (y < int'(SAMPLE_MIN))
        begin
            y = SAMPLE_MIN;
        end
        clip_hist[ch][0] = sample_t'(q4);
        clip_hist[ch][1] = sample_t'(q3);
        clip_hist[ch][2] = sample_t'(q2);
        prev_sample[ch]  = x;
        r.channel = ch;
        r.sample  = sample_t'(y);
        return r;
    endfunction

    // Random sample with a bias toward full scale, the clip levels and small
    // values, so that clipping, rounding and steep steps all come up often.
    function automatic sample_t random_sample();
        int pick;
        pick = $urandom_range(9);
        case (pick)
            0, 1, 2, 3:
                return sample_t'($urandom);
            4:
                case ($urandom_range(3))
                    0:       return SAMPLE_MAX;
                    1:       return SAMPLE_MIN;
                    2:       return sample_t'(0);
                    default: return sample_t'(-1);
                endcase
            5:
                return sample_t'(($urandom_range(1) ? int'(low_thr) : int'(high_thr))
                                 + int'($urandom_range(8)) - 4);
            6:
                return sample_t'(int'($urandom_range(512)) - 256);
            7:
                return sample_t'(int'(SAMPLE_MAX) - int'($urandom_range(31)));
            default:
                return sample_t'(int'(SAMPLE_MIN) + int'($urandom_range(31)));
        endcase
    endfunction

    // Both clip levels are written back to back while the block is idle; the
    // local copy follows once the second write has landed.
    task automatic write_thresholds(sample_t lo, sample_t hi);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_LOW_THR;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_index <= REG_HIGH_THR;
        cfg_data  <= hi;
        @(posedge clk);
        cfg_we    <= 1'b0;
        low_thr  = lo;
        high_thr = hi;
    endtask

    // Queue checks happen on the falling edge so they never race the clocked
    // driver and monitor. Quiet means nothing queued, nothing offered and
    // nothing still owed by the block.
    task automatic wait_quiet();
        do
        begin
            @(negedge clk);
        end
        while (pending_beats.size() != 0 || sample_bus.valid || expected_results.size() != 0);
    endtask

    // Driver. A beat accepted on this edge is predicted right away, using the
    // values still on the bus. A new beat is loaded when the bus is free or
    // the current beat is leaving, unless the sender chooses to idle.
    always @(posedge clk)
    begin : drive_samples
        in_beat_t nxt;
        if (rst_n)
        begin
            if (sample_bus.valid && sample_bus.ready)
            begin
                expected_results.push_back(
                    clip_and_decimate(sample_bus.channel, sample_bus.sample_in));
            end
            if (!sample_bus.valid || sample_bus.ready)
            begin
                if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = pending_beats.pop_front();
                    sample_bus.valid     <= 1'b1;
                    sample_bus.channel   <= nxt.channel;
                    sample_bus.sample_in <= nxt.sample;
                end
                else
                begin
                    sample_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor. Every accepted result must match the oldest expectation in both
    // fields; ready is redrawn each cycle to stall the block at random.
    always @(posedge clk)
    begin : check_results
        out_beat_t want;
        if (rst_n)
        begin
            if (result_bus.valid && result_bus.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected beat: expected none, actual channel %0d sample %0d",
                             $time, result_bus.channel_out, result_bus.sample_out);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result_bus.channel_out !== want.channel)
                    begin
                        $display("%0t: channel mismatch: expected %0d, actual %0d",
                                 $time, want.channel, result_bus.channel_out);
                        mismatches++;
                    end
                    if (result_bus.sample_out !== want.sample)
                    begin
                        $display("%0t: sample mismatch on channel %0d: expected %0d, actual %0d",
                                 $time, want.channel, want.sample, result_bus.sample_out);
                        mismatches++;
                    end
                end
            end
            result_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        int      regime;
        int      setting;
        int      i;
        logic    ch;
        sample_t lo;
        sample_t hi;
        sample_t a;
        sample_t b;
        // Full-scale swings in both directions, steady extremes, the smallest
        // steps around zero (odd sums exercise the round-half-up rule) and
        // alternating bit patterns.
        sample_t dir_samples [24] = '{
            SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, 16'sd0, -16'sd1, 16'sd1,
            16'sh5555, 16'shAAAA, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MAX,
            16'sd12345, -16'sd12345, 16'sd2, -16'sd2, 16'sd3, -16'sd3,
            16'sd32766, -16'sd32767, 16'sd16384, -16'sd16384, 16'sh7FFE, 16'sh8001
        };

        clk                  = 1'b0;
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = REG_LOW_THR;
        cfg_data             = '0;
        sample_bus.valid     = 1'b0;
        sample_bus.channel   = 1'b0;
        sample_bus.sample_in = '0;
        result_bus.ready     = 1'b0;
        mismatches           = 0;
        cycle_count          = 0;

        // The state after reset: full-scale levels and cleared history.
        low_thr  = LOW_THR_RST;
        high_thr = HIGH_THR_RST;
        for (i = 0; i < SLOTS; i++)
        begin
            prev_sample[i] = '0;
            for (int k = 0; k < HIST_LEN; k++)
            begin
                clip_hist[i][k] = '0;
            end
        end

        send_idle_pct = 21;
        recv_idle_pct = 63;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed beats at the reset levels, in short runs per channel so that
        // both back-to-back and interleaved history updates occur.
        for (i = 0; i < 24; i++)
        begin
            ch = ((i / 3) % 2) != 0;
            pending_beats.push_back(in_beat_t'{ch, dir_samples[i]});
        end
        wait_quiet();

        // Three idling regimes, each walking through the same list of clip
        // settings: full scale, a narrow window, a random ordered window, the
        // most inverted levels, random levels in either order, both levels at
        // the bottom, both at the top, and both at zero.
        for (regime = 0; regime < 3; regime++)
        begin
            case (regime)
                0:
                begin
                    send_idle_pct = 21;
                    recv_idle_pct = 63;
                end
                1:
                begin
                    send_idle_pct = 63;
                    recv_idle_pct = 21;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (setting = 0; setting < SETTINGS_PER_PASS; setting++)
            begin
                case (setting)
                    0:
                    begin
                        lo = SAMPLE_MIN;
                        hi = SAMPLE_MAX;
                    end
                    1:
                    begin
                        lo = -16'sd8192;
                        hi = 16'sd8191;
                    end
                    2:
                    begin
                        a  = sample_t'($urandom);
                        b  = sample_t'($urandom);
                        lo = (a < b) ? a : b;
                        hi = (a < b) ? b : a;
                    end
                    3:
                    begin
                        lo = SAMPLE_MAX;
                        hi = SAMPLE_MIN;
                    end
                    4:
                    begin
                        lo = sample_t'($urandom);
                        hi = sample_t'($urandom);
                    end
                    5:
                    begin
                        lo = SAMPLE_MIN;
                        hi = SAMPLE_MIN;
                    end
                    6:
                    begin
                        lo = SAMPLE_MAX;
                        hi = SAMPLE_MAX;
                    end
                    default:
                    begin
                        lo = '0;
                        hi = '0;
                    end
                endcase
                write_thresholds(lo, hi);
                @(negedge clk);
                for (i = 0; i < BEATS_PER_SETTING; i++)
                begin
                    pending_beats.push_back(in_beat_t'{1'($urandom_range(1)), random_sample()});
                end
                wait_quiet();
            end
        end

        // Give the block time to show any stray beat before the verdict.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### files.f
design/ohc_pkg.sv
design/ohc_in_if.sv
design/ohc_out_if.sv
design/ohc_interp_clip.sv
design/ohc_decim.sv
design/oversampled_hard_clipper_4x.sv
sim/testbench.sv
